>>> rtl/utcjd_pkg.sv
// Shared types, constants and tables for the UTC to TT Julian date converter.
package utcjd_pkg;

    localparam int FRAC_BITS     = 40;
    localparam int LEAP_ENTRIES  = 28;
    localparam int KNOWN_ENTRIES = 28;
    localparam int TABLE_LEN     = (LEAP_ENTRIES < KNOWN_ENTRIES) ? LEAP_ENTRIES : KNOWN_ENTRIES;

    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SEC_W      = 26;
    localparam int JD_W       = 63;
    localparam int TAI_W      = 6;
    localparam int IN_FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SEC_W;
    localparam int IN_W       = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_W      = ((JD_W + TAI_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_W - JD_W - TAI_W;
    localparam int KEY_W      = YEAR_W + MONTH_W + DAY_W;

    localparam int FRONT_STAGES = 3;
    localparam int FRAC_STAGES  = 4;
    localparam int STAGES       = FRONT_STAGES + FRAC_STAGES + 1;

    // calendar arithmetic
    localparam int YADJ_W      = YEAR_W + 1;
    localparam int YO_W        = YEAR_W + 2;
    localparam int YD_PROD_W   = YO_W + 11;
    localparam int YDAYS_W     = 22;
    localparam int BASE_W      = YDAYS_W + 1;
    localparam int CENT_W      = 6;
    localparam int CENT_RECIP_W = 13;
    localparam int CENT_PROD_W = YEAR_W + CENT_RECIP_W;
    localparam int CENT_SHIFT  = 19;
    localparam int MTERM_W     = 9;

    localparam logic [TAI_W-1:0]        TAI_BASE        = 6'd10;
    localparam logic [MONTH_W-1:0]      MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0]      MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0]      MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]        FIRST_DAY       = 5'd1;
    localparam logic [YO_W-1:0]         YEAR_OFFSET     = 14'd4716;
    localparam logic [YD_PROD_W-1:0]    DAYS_4Y         = 25'd1461;
    localparam logic [CENT_PROD_W-1:0]  CENT_RECIP      = 25'd5243;
    localparam logic [YDAYS_W-1:0]      CENT_BIAS       = 22'd2;
    localparam logic [BASE_W-1:0]       DAY_BASE_OFFSET = 23'd3049;

    // time of day in microseconds
    localparam int NUM_W = 37;
    localparam logic [NUM_W-1:0] US_PER_SEC   = 37'd1000000;
    localparam logic [NUM_W-1:0] TT_OFFSET_US = 37'd32184000;
    localparam logic [NUM_W-1:0] MIN_US_60    = 37'd60000000;
    localparam logic [NUM_W-1:0] MIN_US_61    = 37'd61000000;
    localparam logic [NUM_W-1:0] HOUR_US_60   = 37'd3600000000;
    localparam logic [NUM_W-1:0] HOUR_US_61   = 37'd3660000000;
    localparam logic [NUM_W-1:0] DEN_60       = 37'd86400000000;
    localparam logic [NUM_W-1:0] DEN_61       = 37'd87840000000;

    // fraction by reciprocal multiply: frac = (rem * RECIP) >> RECIP_SHIFT
    localparam int DEN_SHIFT   = 11;
    localparam int RECIP_SHIFT = 64;
    localparam int PIECE_W     = 23;
    localparam int CPARTS      = 3;
    localparam int RPARTS      = 2;
    localparam int RECIP_W     = CPARTS * PIECE_W;
    localparam int RLO_W       = 19;
    localparam int PP_W        = RLO_W + PIECE_W;
    localparam int PSUM_W      = PP_W + (CPARTS - 1) * PIECE_W;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam logic [127:0] RECIP_ONE = 128'd1 << (FRAC_BITS - DEN_SHIFT + RECIP_SHIFT);
    localparam logic [127:0] K_60      = 128'(DEN_60 >> DEN_SHIFT);
    localparam logic [127:0] K_61      = 128'(DEN_61 >> DEN_SHIFT);
    localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'((RECIP_ONE + K_60 - 128'd1) / K_60);
    localparam logic [RECIP_W-1:0] RECIP_61 = RECIP_W'((RECIP_ONE + K_61 - 128'd1) / K_61);

    // floor(30.6001 * (m + 1)) indexed by adjusted month m
    localparam logic [MTERM_W-1:0] MONTH_TERM [16] = '{
        9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
        9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
    };

    localparam logic [YEAR_W-1:0] LEAP_YEAR [KNOWN_ENTRIES] = '{
        12'd1972, 12'd1972, 12'd1973, 12'd1974, 12'd1975, 12'd1976, 12'd1977,
        12'd1978, 12'd1979, 12'd1980, 12'd1981, 12'd1982, 12'd1983, 12'd1985,
        12'd1988, 12'd1990, 12'd1991, 12'd1992, 12'd1993, 12'd1994, 12'd1996,
        12'd1997, 12'd1999, 12'd2006, 12'd2009, 12'd2012, 12'd2015, 12'd2017
    };
    localparam logic [MONTH_W-1:0] LEAP_MONTH [KNOWN_ENTRIES] = '{
        4'd1, 4'd7, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd7,
        4'd1, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd1
    };

    typedef struct packed {
        logic [SEC_W-1:0]    second_us;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } utcjd_in_t;

    typedef struct packed {
        logic [TAI_W-1:0]  tai;
        logic [BASE_W-1:0] day_base;
    } utcjd_side_t;

    typedef struct packed {
        logic              table_date;
        utcjd_side_t       side;
        logic [NUM_W-1:0]  num;
    } utcjd_num_t;

    typedef struct packed {
        utcjd_side_t          side;
        logic                 q;
        logic [FRAC_BITS-1:0] frac;
    } utcjd_frac_t;

endpackage

>>> rtl/utcjd_front.sv
// Leap-second lookup, calendar day number and time-of-day numerator stages.
module utcjd_front (
    input  logic                                    aclk,
    input  logic [utcjd_pkg::FRONT_STAGES-1:0]      ld,
    input  utcjd_pkg::utcjd_in_t                    in_data,
    output utcjd_pkg::utcjd_num_t                   out_data
);
    import utcjd_pkg::*;

    utcjd_in_t               in_reg;

    logic [KEY_W-1:0]        key;
    logic [TABLE_LEN-1:0]    ge;
    logic [TAI_W-1:0]        cnt;
    logic                    jan_feb;
    logic [YADJ_W-1:0]       y_adj;
    logic [YO_W-1:0]         yo;
    logic [CENT_PROD_W-1:0]  cent_prod;
    logic [NUM_W-1:0]        min60, min61, hr60, hr61;

    logic [TAI_W-1:0]        tai_next, tai_reg;
    logic                    table_date_next, table_date_reg;
    logic [CENT_W-1:0]       cent_next, cent_reg;
    logic [YDAYS_W-1:0]      year_days_next, year_days_reg;
    logic [MONTH_W-1:0]      m_adj_next, m_adj_reg;
    logic [NUM_W-1:0]        hm_us_next, hm_us_reg;
    logic [DAY_W-1:0]        day_reg;
    logic [SEC_W-1:0]        sec_us_reg;

    logic [YDAYS_W-1:0]      dnum;
    utcjd_num_t              out_next, out_reg;

    always_comb begin
        key = {in_reg.year, in_reg.month, in_reg.day};
        jan_feb = in_reg.month inside {MONTH_JAN, MONTH_FEB};
        y_adj = {1'b0, in_reg.year} - YADJ_W'(jan_feb);
        m_adj_next = jan_feb ? in_reg.month + MONTHS_PER_YEAR : in_reg.month;
        cnt = '0;
        table_date_next = 1'b0;
        for (int i = 0; i < TABLE_LEN; i++) begin
            ge[i] = key >= {LEAP_YEAR[i], LEAP_MONTH[i], FIRST_DAY};
            cnt = cnt + TAI_W'(ge[i]);
            if (y_adj == {1'b0, LEAP_YEAR[i]} && m_adj_next == LEAP_MONTH[i]
                    && in_reg.day == FIRST_DAY) begin
                table_date_next = 1'b1;
            end
        end
        tai_next = ge[0] ? cnt + TAI_BASE - TAI_W'(1) : TAI_BASE;

        cent_prod = CENT_PROD_W'(y_adj[YEAR_W-1:0]) * CENT_RECIP;
        cent_next = y_adj[YEAR_W] ? '0 : CENT_W'(cent_prod >> CENT_SHIFT);

        yo = {y_adj[YADJ_W-1], y_adj} + YEAR_OFFSET;
        year_days_next = YDAYS_W'((YD_PROD_W'(yo) * DAYS_4Y) >> 2);

        min60 = NUM_W'(in_reg.minute) * MIN_US_60;
        min61 = NUM_W'(in_reg.minute) * MIN_US_61;
        hr60  = NUM_W'(in_reg.hour) * HOUR_US_60;
        hr61  = NUM_W'(in_reg.hour) * HOUR_US_61;
        hm_us_next = table_date_next ? min61 + hr61 : min60 + hr60;
    end

    always_comb begin
        dnum = year_days_reg + YDAYS_W'(MONTH_TERM[m_adj_reg]) + YDAYS_W'(day_reg)
             + CENT_BIAS - YDAYS_W'(cent_reg) + YDAYS_W'(cent_reg >> 2);
        out_next.table_date    = table_date_reg;
        out_next.side.tai      = tai_reg;
        out_next.side.day_base = {dnum, 1'b0} - DAY_BASE_OFFSET;
        out_next.num = NUM_W'(sec_us_reg) + NUM_W'(tai_reg) * US_PER_SEC
                     + TT_OFFSET_US + hm_us_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            in_reg <= in_data;
        end
        if (ld[1]) begin
            tai_reg        <= tai_next;
            table_date_reg <= table_date_next;
            cent_reg       <= cent_next;
            year_days_reg  <= year_days_next;
            m_adj_reg      <= m_adj_next;
            hm_us_reg      <= hm_us_next;
            day_reg        <= in_reg.day;
            sec_us_reg     <= in_reg.second_us;
        end
        if (ld[2]) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/utcjd_frac.sv
// Whole-day carry and day fraction by pipelined reciprocal multiply.
module utcjd_frac (
    input  logic                                    aclk,
    input  logic [utcjd_pkg::FRAC_STAGES-1:0]       ld,
    input  utcjd_pkg::utcjd_num_t                   in_data,
    output utcjd_pkg::utcjd_frac_t                  out_data
);
    import utcjd_pkg::*;

    logic [NUM_W-1:0]   den;
    logic               q_next;
    logic [NUM_W-1:0]   rem_next, rem_reg;
    logic               q3_reg, td3_reg;
    utcjd_side_t        side3_reg;

    logic [RECIP_W-1:0] recip;
    logic [RLO_W-1:0]   r_part [RPARTS];
    logic [PP_W-1:0]    pp_next [RPARTS][CPARTS];
    logic [PP_W-1:0]    pp_reg  [RPARTS][CPARTS];
    logic               q4_reg;
    utcjd_side_t        side4_reg;

    logic [PSUM_W-1:0]  psum_next [RPARTS];
    logic [PSUM_W-1:0]  psum_reg  [RPARTS];
    logic               q5_reg;
    utcjd_side_t        side5_reg;

    logic [PROD_W-1:0]  prod;
    utcjd_frac_t        out_next, out_reg;

    always_comb begin
        den = in_data.table_date ? DEN_61 : DEN_60;
        q_next = in_data.num >= den;
        rem_next = q_next ? in_data.num - den : in_data.num;
    end

    always_comb begin
        recip = td3_reg ? RECIP_61 : RECIP_60;
        r_part[0] = rem_reg[RLO_W-1:0];
        r_part[1] = RLO_W'(rem_reg[NUM_W-1:RLO_W]);
        for (int i = 0; i < RPARTS; i++) begin
            for (int j = 0; j < CPARTS; j++) begin
                pp_next[i][j] = PP_W'(r_part[i]) * PP_W'(recip[j*PIECE_W +: PIECE_W]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < RPARTS; i++) begin
            psum_next[i] = PSUM_W'(pp_reg[i][0])
                         + (PSUM_W'(pp_reg[i][1]) << PIECE_W)
                         + (PSUM_W'(pp_reg[i][2]) << (2 * PIECE_W));
        end
    end

    always_comb begin
        prod = PROD_W'(psum_reg[0]) + (PROD_W'(psum_reg[1]) << RLO_W);
        out_next.side = side5_reg;
        out_next.q    = q5_reg;
        out_next.frac = prod[RECIP_SHIFT +: FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            rem_reg   <= rem_next;
            q3_reg    <= q_next;
            td3_reg   <= in_data.table_date;
            side3_reg <= in_data.side;
        end
        if (ld[1]) begin
            pp_reg    <= pp_next;
            q4_reg    <= q3_reg;
            side4_reg <= side3_reg;
        end
        if (ld[2]) begin
            psum_reg  <= psum_next;
            q5_reg    <= q4_reg;
            side5_reg <= side4_reg;
        end
        if (ld[3]) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/utc_date_to_tt_julian_date_top.sv
// Top level of the UTC calendar date to TT Julian date converter.
//
//  port group   dir  payload (low bit first)
//  s_ request   in   year, month, day, hour, minute, second_us
//  m_ request   out  julian_date_tt (Q23.40), tai_minus_utc
//
//  One request per cycle while m_ is not stalled; each request passes the input register
//  and seven stages: lookup, day number, carry, partial products, two adder stages,
//  and the output add, before m_tvalid rises.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage holds while full and its successor holds; empty stages fill
//  even while m_ is stalled, so s_tready stays high until the pipe is full.
module utc_date_to_tt_julian_date_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second_us[57:32], zero[63:58]
    input  logic [utcjd_pkg::IN_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // julian_date_tt[62:0], tai_minus_utc[68:63], zero[71:69]
    output logic [utcjd_pkg::OUT_W-1:0]   m_tdata
);
    import utcjd_pkg::*;

    logic [STAGES-1:0] valid_reg, valid_next, ld;
    utcjd_in_t         in_fields;
    utcjd_num_t        num_data;
    utcjd_frac_t       frac_data;
    logic [JD_W-1:0]   jd_next, jd_reg;
    logic [TAI_W-1:0]  tai_reg;

    assign in_fields = s_tdata[IN_FIELDS_W-1:0];

    always_comb begin
        ld[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        valid_next = valid_reg;
        if (ld[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (ld[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    utcjd_front u_front (
        .aclk     (aclk),
        .ld       (ld[FRONT_STAGES-1:0]),
        .in_data  (in_fields),
        .out_data (num_data)
    );

    utcjd_frac u_frac (
        .aclk     (aclk),
        .ld       (ld[FRONT_STAGES +: FRAC_STAGES]),
        .in_data  (num_data),
        .out_data (frac_data)
    );

    assign jd_next = (JD_W'(frac_data.side.day_base) << (FRAC_BITS - 1))
                   + JD_W'({frac_data.q, frac_data.frac});

    always_ff @(posedge aclk) begin
        if (ld[STAGES-1]) begin
            jd_reg  <= jd_next;
            tai_reg <= frac_data.side.tai;
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {OUT_PAD_W'(0), tai_reg, jd_reg};

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the UTC to TT Julian date converter stream block.
`timescale 1ns / 1ps

module tb_top;
    import utcjd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 700;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 100;
    localparam int LEAP_COUNT     = 28;

    localparam bit [YEAR_W-1:0] LS_YEAR [LEAP_COUNT] = '{
        12'd1972, 12'd1972, 12'd1973, 12'd1974, 12'd1975, 12'd1976, 12'd1977,
        12'd1978, 12'd1979, 12'd1980, 12'd1981, 12'd1982, 12'd1983, 12'd1985,
        12'd1988, 12'd1990, 12'd1991, 12'd1992, 12'd1993, 12'd1994, 12'd1996,
        12'd1997, 12'd1999, 12'd2006, 12'd2009, 12'd2012, 12'd2015, 12'd2017
    };
    localparam bit [MONTH_W-1:0] LS_MONTH [LEAP_COUNT] = '{
        4'd1, 4'd7, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd7,
        4'd1, 4'd7, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd1
    };

    typedef struct {
        bit [JD_W-1:0]  jd;
        bit [TAI_W-1:0] tai;
        bit             table_date;
    } tt_date_t;

    class jd_scoreboard;
        tt_date_t    expected_dates [$];
        int unsigned failures;
        int unsigned requests;
        int unsigned results;
        int unsigned table_hits;
        int unsigned odd_fields;

        function new();
            failures   = 0;
            requests   = 0;
            results    = 0;
            table_hits = 0;
            odd_fields = 0;
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        function tt_date_t tt_julian(utcjd_in_t r);
            tt_date_t    res;
            bit [20:0]   key;
            int unsigned tai;
            longint      y;
            longint      m;
            longint      cent;
            longint      b;
            longint      dnum;
            bit [63:0]   s_tt;
            bit [63:0]   num;
            bit [63:0]   den;
            bit [63:0]   q;
            bit [63:0]   rem;
            bit [63:0]   frac;
            bit [63:0]   base;
            bit [63:0]   jd;
            bit          on_table;

            key = {r.year, r.month, r.day};
            tai = 10;
            for (int i = 0; i < LEAP_COUNT; i++) begin
                if (key < {LS_YEAR[i], LS_MONTH[i], 5'd1})
                    break;
                tai = 10 + i;
            end
            s_tt = 64'(r.second_us) + 64'(tai) * 64'd1000000 + 64'd32184000;

            // January and February count as months 13 and 14 of the prior year
            y = longint'(r.year);
            m = longint'(r.month);
            if (m == 1 || m == 2) begin
                y = y - 1;
                m = m + 12;
            end
            cent = y / 100;
            b    = 2 - cent + cent / 4;
            dnum = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000
                   + longint'(r.day) + b;

            on_table = 1'b0;
            for (int i = 0; i < LEAP_COUNT; i++) begin
                if (y == longint'(LS_YEAR[i]) && m == longint'(LS_MONTH[i]) && r.day == 5'd1)
                    on_table = 1'b1;
            end

            if (on_table) begin
                num = s_tt + 64'd61000000 * 64'(r.minute) + 64'd3660000000 * 64'(r.hour);
                den = 64'd87840000000;
            end else begin
                num = s_tt + 64'd60000000 * 64'(r.minute) + 64'd3600000000 * 64'(r.hour);
                den = 64'd86400000000;
            end

            q    = num / den;
            rem  = num % den;
            frac = '0;
            for (int k = 0; k < FRAC_BITS; k++) begin
                rem  = rem << 1;
                frac = frac << 1;
                if (rem >= den) begin
                    rem     = rem - den;
                    frac[0] = 1'b1;
                end
            end

            base = 64'(2 * dnum - 3049) << (FRAC_BITS - 1);
            jd   = base + (q << FRAC_BITS) + frac;

            res.jd         = jd[JD_W-1:0];
            res.tai        = tai[TAI_W-1:0];
            res.table_date = on_table;
            return res;
        endfunction

        function void note_request(utcjd_in_t r);
            tt_date_t res;
            res = tt_julian(r);
            expected_dates.push_back(res);
            requests++;
            if (res.table_date)
                table_hits++;
            if (r.year < 12'd1900 || r.year > 12'd2100 || r.month == 4'd0 || r.month > 4'd12
                || r.day == 5'd0 || r.hour > 5'd23 || r.minute > 6'd59
                || r.second_us > 26'd60999999)
                odd_fields++;
        endfunction

        function void check_result(bit [OUT_W-1:0] data);
            tt_date_t exp_date;
            bit [JD_W-1:0]  got_jd;
            bit [TAI_W-1:0] got_tai;

            got_jd  = data[JD_W-1:0];
            got_tai = data[JD_W+TAI_W-1:JD_W];
            results++;
            if (expected_dates.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result, actual jd %h tai %0d",
                             $time, got_jd, got_tai);
                return;
            end
            exp_date = expected_dates.pop_front();
            if (got_jd !== exp_date.jd) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: julian_date_tt mismatch, expected %h, actual %h",
                             $time, exp_date.jd, got_jd);
            end
            if (got_tai !== exp_date.tai) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: tai_minus_utc mismatch, expected %0d, actual %0d",
                             $time, exp_date.tai, got_tai);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    jd_scoreboard sb;
    bit           calm = 1'b0;
    int           idle_cycles = 0;

    utc_date_to_tt_julian_date_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic utcjd_in_t mk(int y, int mo, int d, int h, int mi, int us);
        utcjd_in_t r;
        r.year      = YEAR_W'(y);
        r.month     = MONTH_W'(mo);
        r.day       = DAY_W'(d);
        r.hour      = HOUR_W'(h);
        r.minute    = MINUTE_W'(mi);
        r.second_us = SEC_W'(us);
        return r;
    endfunction

    function automatic utcjd_in_t random_date_time();
        utcjd_in_t r;
        int        kind;
        int        i;

        kind = $urandom_range(0, 99);
        r = mk($urandom_range(1900, 2100), $urandom_range(1, 12), $urandom_range(1, 31),
               $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 60999999));
        if (kind >= 60 && kind < 82) begin
            // land on or next to a leap-second boundary
            i = $urandom_range(0, LEAP_COUNT - 1);
            r.year  = LS_YEAR[i];
            r.month = LS_MONTH[i];
            r.day   = 5'd1;
            case ($urandom_range(0, 3))
                1: begin
                    r.day = DAY_W'($urandom_range(2, 3));
                end
                2: begin
                    r.day = DAY_W'($urandom_range(28, 31));
                    if (r.month == 4'd1) begin
                        r.month = 4'd12;
                        r.year  = r.year - 12'd1;
                    end else begin
                        r.month = r.month - 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end else if (kind >= 82) begin
            r = utcjd_in_t'({$urandom(), $urandom()});
        end
        return r;
    endfunction

    task automatic send_request(input utcjd_in_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(req);
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_request(req);
    endtask

    // result side: random stalls, one long hold once the pipe has traffic
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit held;
        bit ready_now;

        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && sb.requests >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_now = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_now = 1'b0;
            end else begin
                ready_now = 1'b1;
                if (!calm && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
            m_tready <= ready_now;
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        utcjd_in_t directed [$];

        sb = new();
        directed.push_back(mk(1900, 1, 1, 0, 0, 0));
        directed.push_back(mk(2100, 12, 31, 23, 59, 60999999));
        directed.push_back(mk(1971, 12, 31, 23, 59, 59999999));
        directed.push_back(mk(1972, 1, 1, 0, 0, 0));
        directed.push_back(mk(1972, 6, 30, 23, 59, 60500000));
        directed.push_back(mk(1972, 7, 1, 0, 0, 0));
        directed.push_back(mk(1972, 7, 1, 23, 59, 60999999));
        directed.push_back(mk(2016, 12, 31, 23, 59, 60000000));
        directed.push_back(mk(2017, 1, 1, 0, 0, 0));
        directed.push_back(mk(2015, 7, 1, 12, 30, 30000000));
        directed.push_back(mk(1973, 1, 1, 6, 0, 0));
        directed.push_back(mk(0, 1, 1, 0, 0, 0));
        directed.push_back(mk(0, 2, 29, 12, 0, 0));
        directed.push_back(mk(4095, 15, 31, 31, 63, 67108863));
        directed.push_back(mk(0, 0, 0, 0, 0, 0));
        directed.push_back(mk(2000, 13, 1, 0, 0, 0));
        directed.push_back(mk(2000, 0, 15, 8, 20, 0));
        directed.push_back(mk(1999, 14, 10, 1, 2, 3));
        directed.push_back(mk(2024, 2, 0, 23, 59, 59999999));
        directed.push_back(mk(2012, 7, 1, 31, 63, 0));
        directed.push_back(mk(1985, 7, 1, 0, 0, 67108863));
        directed.push_back(mk(4095, 12, 31, 0, 0, 0));
        directed.push_back(mk(2100, 2, 28, 12, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_request(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 120 && n < 220);
            send_request(random_date_time());
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d dates, %0d results checked, %0d on leap-second boundary days.",
                 sb.requests, sb.results, sb.table_hits);
        $display("%0d requests carried out-of-range calendar or time fields.", sb.odd_fields);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/utcjd_pkg.sv
rtl/utcjd_front.sv
rtl/utcjd_frac.sv
rtl/utc_date_to_tt_julian_date_top.sv
tb/sv/tb_top.sv
